@@ rtl/gps_satellite_clock_correction_core_macros.svh @@
// ---------------------------------------------------------------------------
// gps_satellite_clock_correction_core assertion macros
// Shared concurrent assertion shorthands for the checker.
// ---------------------------------------------------------------------------
`ifndef GPS_SATELLITE_CLOCK_CORRECTION_CORE_MACROS_SVH
`define GPS_SATELLITE_CLOCK_CORRECTION_CORE_MACROS_SVH

// Same-cycle implication, masked during reset
`define GPSCC_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("gpscc: implication check failed");

// Next-cycle implication, masked during reset
`define GPSCC_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("gpscc: next-cycle check failed");

// Checked at every edge, reset included
`define GPSCC_ASSERT_ALW(label, clk, p) \
  label: assert property (@(posedge clk) (p)) \
    else $error("gpscc: invariant check failed");

`endif

@@ rtl/gpscc_pkg.sv @@
// ---------------------------------------------------------------------------
// gpscc_pkg
// Widths, register indices, constants and helpers for the clock correction.
// ---------------------------------------------------------------------------
package gpscc_pkg;

  localparam int SINE_ITERATIONS_DEF = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int WEEK_W     = 36;
  localparam int ANG_W      = 32;
  localparam int OUT_W      = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_BIAS       = 4'd0,
    REG_CLOCK_DRIFT      = 4'd1,
    REG_CLOCK_DRIFT_RATE = 4'd2,
    REG_CLOCK_EPOCH      = 4'd3,
    REG_ECCENTRICITY     = 4'd4,
    REG_ROOT_A           = 4'd5,
    REG_GROUP_DELAY      = 4'd6,
    REG_SUB_GROUP_DELAY  = 4'd7
  } cfg_reg_t;

  localparam logic signed [37:0] HALF_WEEK = 38'sd19818086400;
  localparam logic signed [37:0] FULL_WEEK = 38'sd39636172800;
  localparam logic [31:0]        F_MAG     = 32'd4097766769;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [33:0] QUARTER   = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;

  // atan(2^-i) in 2^-31 semicircles
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat48(input logic signed [OUT_W:0] v);
    logic signed [OUT_W-1:0] r;
    if (v[OUT_W] != v[OUT_W-1]) begin
      r = v[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/gps_satellite_clock_correction_core.sv @@
// ---------------------------------------------------------------------------
// gps_satellite_clock_correction_core
// Broadcast satellite clock correction: polynomial, relativistic and total.
// ---------------------------------------------------------------------------
// Usage
//  - Load the ephemeris clock terms through the cfg channel (cfg_index,
//    cfg_data) while no query is in flight; cfg_ready is always high and
//    unknown indices are dropped.
//  - Each in-channel transfer (week_time, ecc_anomaly) yields exactly one
//    out-channel transfer carrying total, polynomial and relativistic
//    corrections in 2^-50 s, saturated to 48 bits.
//  - The pipeline depth is set by the CORDIC: one rotation per stage.
//    Throughput is one query per cycle while out_ready is high.
//  - Each stage holds its own valid bit. When out_ready is low, stages
//    close up behind the waiting result, so in_ready stays high until
//    the pipeline is full; nothing is dropped or repeated.
//  - Synchronous reset empties the pipeline and clears the config registers.
// ---------------------------------------------------------------------------
module gps_satellite_clock_correction_core #(
  parameter int SINE_ITERATIONS = gpscc_pkg::SINE_ITERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gpscc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gpscc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [gpscc_pkg::WEEK_W-1:0]          week_time,
  input  logic signed [gpscc_pkg::ANG_W-1:0]    ecc_anomaly,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gpscc_pkg::OUT_W-1:0]    total_correction,
  output logic signed [gpscc_pkg::OUT_W-1:0]    poly_correction,
  output logic signed [gpscc_pkg::OUT_W-1:0]    relativity_correction
);
  import gpscc_pkg::*;

  // rotations are capped at the table length
  localparam int N = (SINE_ITERATIONS > 32) ? 32 : SINE_ITERATIONS;
  localparam int L = N + 3;

  // ---- configuration registers ----
  logic signed [21:0] clock_bias;
  logic signed [15:0] clock_drift;
  logic signed [7:0]  clock_drift_rate;
  logic [15:0]        clock_epoch;
  logic [31:0]        orbit_eccentricity;
  logic [31:0]        root_semi_major_axis;
  logic signed [7:0]  group_delay;
  logic               subtract_group_delay;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_bias           <= '0;
      clock_drift          <= '0;
      clock_drift_rate     <= '0;
      clock_epoch          <= '0;
      orbit_eccentricity   <= '0;
      root_semi_major_axis <= '0;
      group_delay          <= '0;
      subtract_group_delay <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CLOCK_BIAS:       clock_bias           <= cfg_data[21:0];
        REG_CLOCK_DRIFT:      clock_drift          <= cfg_data[15:0];
        REG_CLOCK_DRIFT_RATE: clock_drift_rate     <= cfg_data[7:0];
        REG_CLOCK_EPOCH:      clock_epoch          <= cfg_data[15:0];
        REG_ECCENTRICITY:     orbit_eccentricity   <= cfg_data;
        REG_ROOT_A:           root_semi_major_axis <= cfg_data;
        REG_GROUP_DELAY:      group_delay          <= cfg_data[7:0];
        REG_SUB_GROUP_DELAY:  subtract_group_delay <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- stage valids and per-stage advance ----
  // A stage may load when it is empty or its contents move on.
  logic [L:1] v;
  logic [L:1] en;

  always_comb begin
    en[L] = !v[L] || out_ready;
    for (int k = L - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v[L];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      for (int k = 2; k <= L; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // ---- stage 1: time since epoch, angle fold, e*sqrtA ----
  logic signed [37:0] dt_raw, dt_wrap;
  logic signed [33:0] ang_ext, ang_fold;

  always_comb begin
    dt_raw = $signed({2'b00, week_time}) - $signed({2'b00, clock_epoch, 20'b0});
    if (dt_raw > HALF_WEEK) begin
      dt_wrap = dt_raw - FULL_WEEK;
    end else if (dt_raw < -HALF_WEEK) begin
      dt_wrap = dt_raw + FULL_WEEK;
    end else begin
      dt_wrap = dt_raw;
    end
    ang_ext = {{2{ecc_anomaly[31]}}, ecc_anomaly};
    // sin(pi - E) = sin(E)
    if (ang_ext > QUARTER) begin
      ang_fold = HALF_TURN - ang_ext;
    end else if (ang_ext < -QUARTER) begin
      ang_fold = -HALF_TURN - ang_ext;
    end else begin
      ang_fold = ang_ext;
    end
  end

  logic [34:0]        s1_adt;
  logic               s1_dneg;
  logic [63:0]        s1_es;
  logic signed [33:0] cx [1:N+1];
  logic signed [33:0] cy [1:N+1];
  logic signed [33:0] cz [1:N+1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_adt  <= dt_wrap[37] ? 35'(-dt_wrap) : dt_wrap[34:0];
      s1_dneg <= dt_wrap[37];
      s1_es   <= 64'(orbit_eccentricity) * 64'(root_semi_major_axis);
      cx[1]   <= CORDIC_X0;
      cy[1]   <= '0;
      cz[1]   <= ang_fold;
    end
  end

  // ---- stage 2: first products ----
  logic [15:0] af1_mag;
  logic [7:0]  af2_mag;
  assign af1_mag = clock_drift[15] ? 16'(-clock_drift) : clock_drift;
  assign af2_mag = clock_drift_rate[7] ? 8'(-clock_drift_rate) : clock_drift_rate;

  logic [50:0] s2_m1;
  logic [42:0] s2_p;
  logic [34:0] s2_adt;
  logic        s2_dneg;
  logic [63:0] s2_efl, s2_efh;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_m1   <= 51'(af1_mag) * 51'(s1_adt);
      s2_p    <= 43'(af2_mag) * 43'(s1_adt);
      s2_adt  <= s1_adt;
      s2_dneg <= s1_dneg;
      s2_efl  <= 64'(s1_es[31:0]) * 64'(F_MAG);
      s2_efh  <= 64'(s1_es[63:32]) * 64'(F_MAG);
    end
  end

  // ---- stage 3: drift term, dt^2 partial products, r1 ----
  logic [51:0] m1_rnd;
  logic [95:0] ef_sum;
  assign m1_rnd = 52'(s2_m1) + 52'd256;
  assign ef_sum = {s2_efh, 32'b0} + {32'b0, s2_efl};

  logic signed [42:0] s3_t1;
  logic [60:0]        s3_ppl;
  logic [59:0]        s3_pph;
  logic [63:0]        r1p [3:N+1];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_t1  <= (clock_drift[15] ^ s2_dneg) ? -$signed({1'b0, m1_rnd[50:9]})
                                             :  $signed({1'b0, m1_rnd[50:9]});
      s3_ppl <= 61'(s2_p) * 61'(s2_adt[17:0]);
      s3_pph <= 60'(s2_p) * 60'(s2_adt[34:18]);
      r1p[3] <= ef_sum[95:32];
    end
  end

  // ---- stage 4: drift-rate term and polynomial ----
  logic [78:0]        pp_sum;
  logic signed [42:0] t2;
  logic signed [45:0] poly_sum;
  logic signed [45:0] polyp [4:N+2];

  always_comb begin
    pp_sum = 79'(s3_ppl) + (79'(s3_pph) << 18) + (79'(1) << 36);
    t2 = clock_drift_rate[7] ? -$signed({1'b0, pp_sum[78:37]})
                             :  $signed({1'b0, pp_sum[78:37]});
    poly_sum = 46'($signed({clock_bias, 19'b0})) + 46'(s3_t1) + 46'(t2);
  end

  always_ff @(posedge clk) begin
    if (en[4]) polyp[4] <= poly_sum;
  end

  // ---- carry lines ----
  for (genvar k = 5; k <= N + 2; k++) begin : g_poly
    always_ff @(posedge clk) begin
      if (en[k]) polyp[k] <= polyp[k-1];
    end
  end

  for (genvar k = 4; k <= N + 1; k++) begin : g_r1
    always_ff @(posedge clk) begin
      if (en[k]) r1p[k] <= r1p[k-1];
    end
  end

  // ---- CORDIC, one rotation per stage ----
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic [33:0] ATAN_I = 34'(atan_lut(5'(i)));
    always_ff @(posedge clk) begin
      if (en[i+2]) begin
        if (cz[i+1] >= 0) begin
          cx[i+2] <= cx[i+1] - (cy[i+1] >>> i);
          cy[i+2] <= cy[i+1] + (cx[i+1] >>> i);
          cz[i+2] <= cz[i+1] - $signed(ATAN_I);
        end else begin
          cx[i+2] <= cx[i+1] + (cy[i+1] >>> i);
          cy[i+2] <= cy[i+1] - (cx[i+1] >>> i);
          cz[i+2] <= cz[i+1] + $signed(ATAN_I);
        end
      end
    end
  end

  // ---- stage N+2: r1 * |sin| partial products ----
  logic [32:0] s_mag;
  assign s_mag = cy[N+1][33] ? 33'(-cy[N+1]) : cy[N+1][32:0];

  logic [64:0] rr_lo, rr_hi;
  logic        s_neg;

  always_ff @(posedge clk) begin
    if (en[N+2]) begin
      rr_lo <= 65'(r1p[N+1][31:0]) * 65'(s_mag);
      rr_hi <= 65'(r1p[N+1][63:32]) * 65'(s_mag);
      s_neg <= cy[N+1][33];
    end
  end

  // ---- output stage: round, combine, saturate ----
  logic [97:0]         rr_sum;
  logic signed [35:0]  rel;
  logic signed [OUT_W:0] total_w;

  always_comb begin
    rr_sum = 98'(rr_lo) + (98'(rr_hi) << 32) + (98'(1) << 62);
    // sign opposite to that of the sine
    rel = s_neg ? $signed({1'b0, rr_sum[97:63]}) : -$signed({1'b0, rr_sum[97:63]});
    total_w = (OUT_W+1)'(polyp[N+2]) + (OUT_W+1)'(rel);
    if (subtract_group_delay) begin
      total_w = total_w - (OUT_W+1)'($signed({group_delay, 19'b0}));
    end
  end

  always_ff @(posedge clk) begin
    if (en[L]) begin
      total_correction      <= sat48(total_w);
      poly_correction       <= sat48((OUT_W+1)'(polyp[N+2]));
      relativity_correction <= sat48((OUT_W+1)'(rel));
    end
  end

endmodule

@@ rtl/gpscc_checker.sv @@
// ---------------------------------------------------------------------------
// gpscc_checker
// Port-level checks on the clock correction core, bound to the core module.
// ---------------------------------------------------------------------------
`include "gps_satellite_clock_correction_core_macros.svh"

module gpscc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [gpscc_pkg::OUT_W-1:0]    total_correction,
  input logic signed [gpscc_pkg::OUT_W-1:0]    poly_correction,
  input logic signed [gpscc_pkg::OUT_W-1:0]    relativity_correction
);

  // held result stays put
  `GPSCC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(total_correction) && $stable(poly_correction) && $stable(relativity_correction))

  // pipeline is empty straight after reset
  `GPSCC_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // register writes are never back-pressured
  `GPSCC_ASSERT_IMP(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

  // an empty output stage and an idle input must not block the input
  `GPSCC_ASSERT_NXT(a_no_early_block, clk, rst, !out_valid && !in_valid, in_ready)

endmodule

bind gps_satellite_clock_correction_core gpscc_checker u_gpscc_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: satellite clock correction core testbench
// Loads several sets of clock and orbit terms, extremes among them, and runs
// directed and random time/angle queries through the core. Each result is
// checked field by field against an in-bench bit-exact model of the
// polynomial, CORDIC sine and relativistic terms. Both sides stall at random.
// ---------------------------------------------------------------------------
module tb_top;
  import gpscc_pkg::*;

  localparam int  LATENCY    = SINE_ITERATIONS_DEF + 3;
  localparam int  CYCLE_CAP  = 600000;
  localparam int  RAND_ITEMS = 1700;
  localparam longint HALF_WK = 64'sd19818086400;
  localparam longint FULL_WK = 64'sd39636172800;

  typedef struct packed {
    logic signed [OUT_W-1:0] total;
    logic signed [OUT_W-1:0] poly;
    logic signed [OUT_W-1:0] rel;
  } corr_t;

  typedef struct {
    logic [WEEK_W-1:0]       week;
    logic signed [ANG_W-1:0] ang;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WEEK_W-1:0] week_time = '0;
  logic signed [ANG_W-1:0] ecc_anomaly = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] total_correction, poly_correction, relativity_correction;

  // shadow of the core's registers
  logic signed [21:0] af0_r;
  logic signed [15:0] af1_r;
  logic signed [7:0]  af2_r;
  logic [15:0]        epoch_r;
  logic [31:0]        ecc_r;
  logic [31:0]        root_a_r;
  logic signed [7:0]  tgd_r;
  logic               sub_tgd_r;

  corr_t corr_fifo[$];
  corr_t pinned_fifo[$];   // typed-in values, used in place of the model's where the flag is set
  bit    pinned_flag[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    cycles = 0;
  bit    calm = 1'b0;      // no stalling when set

  gps_satellite_clock_correction_core u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic signed [OUT_W-1:0] clamp48(longint v);
    if (v > 64'sd140737488355327) return 48'sh7FFFFFFFFFFF;
    if (v < -64'sd140737488355328) return 48'sh800000000000;
    return v[OUT_W-1:0];
  endfunction

  // bit-exact correction for one query with the current shadow registers
  function automatic corr_t predict_correction(logic [WEEK_W-1:0] wk,
                                               logic signed [ANG_W-1:0] ang);
    longint dt, adt, a1, a2, term1, term2, poly, rel, total;
    longint x, y, z, nx, s;
    logic [127:0] w;
    logic [63:0] m, r1;
    int n;
    corr_t c;
    dt = longint'({28'd0, wk}) - (longint'({48'd0, epoch_r}) <<< 20);
    if (dt > HALF_WK) dt = dt - FULL_WK;
    else if (dt < -HALF_WK) dt = dt + FULL_WK;
    adt = dt < 0 ? -dt : dt;
    a1 = longint'(af1_r);
    a2 = longint'(af2_r);
    m = ((a1 < 0 ? -a1 : a1) * adt + 256) >> 9;
    term1 = ((a1 < 0) != (dt < 0)) ? -longint'(m) : longint'(m);
    w = 128'(a2 < 0 ? -a2 : a2) * 128'(adt) * 128'(adt) + (128'd1 << 36);
    term2 = a2 < 0 ? -longint'(w[100:37]) : longint'(w[100:37]);
    poly = (longint'(af0_r) <<< 19) + term1 + term2;
    // sine by rotation, angle folded into the right half plane
    z = longint'(ang);
    if (z > (64'sd1 <<< 30)) z = (64'sd1 <<< 31) - z;
    else if (z < -(64'sd1 <<< 30)) z = -(64'sd1 <<< 31) - z;
    x = 64'sd652032874;
    y = 0;
    n = SINE_ITERATIONS_DEF > 32 ? 32 : SINE_ITERATIONS_DEF;
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'({32'd0, atan_lut(i[4:0])});
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'({32'd0, atan_lut(i[4:0])});
      end
      x = nx;
    end
    s = y;
    w = 128'(ecc_r) * 128'(root_a_r) * 128'(F_MAG);
    r1 = w[95:32];
    w = 128'(r1) * 128'(s < 0 ? -s : s) + (128'd1 << 62);
    m = w[126:63];
    rel = s < 0 ? longint'(m) : -longint'(m);
    total = poly + rel - (sub_tgd_r ? (longint'(tgd_r) <<< 19) : 64'sd0);
    c.total = clamp48(total);
    c.poly  = clamp48(poly);
    c.rel   = clamp48(rel);
    return c;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  // predict on every input transfer, check on every output transfer
  always @(posedge clk) begin
    corr_t want, pin;
    bit pinned;
    if (!rst && in_valid && in_ready) corr_fifo.push_back(predict_correction(week_time, ecc_anomaly));
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (corr_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing pending at cycle %0d", cycles);
      end else begin
        want = corr_fifo.pop_front();
        pinned = pinned_flag.size() ? pinned_flag.pop_front() : 1'b0;
        pin = pinned_fifo.size() ? pinned_fifo.pop_front() : want;
        if (pinned) want = pin;
        if (total_correction !== want.total || poly_correction !== want.poly ||
            relativity_correction !== want.rel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: total %0d/%0d poly %0d/%0d rel %0d/%0d (exp/got)",
                     results_seen, want.total, total_correction, want.poly,
                     poly_correction, want.rel, relativity_correction);
        end
      end
    end
  end

  // receiver: stall a random number of cycles ahead of each result
  initial begin
    int k;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      k = draw_wait();
      if (k > 0) begin
        out_ready = 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_query(logic [WEEK_W-1:0] wk, logic signed [ANG_W-1:0] ang);
    int k;
    k = draw_wait();
    if (k > 0) begin
      in_valid = 1'b0;
      repeat (k) @(negedge clk);
    end
    week_time   = wk;
    ecc_anomaly = ang;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (cfg_reg_t'(idx))
      REG_CLOCK_BIAS:       af0_r     = data[21:0];
      REG_CLOCK_DRIFT:      af1_r     = data[15:0];
      REG_CLOCK_DRIFT_RATE: af2_r     = data[7:0];
      REG_CLOCK_EPOCH:      epoch_r   = data[15:0];
      REG_ECCENTRICITY:     ecc_r     = data;
      REG_ROOT_A:           root_a_r  = data;
      REG_GROUP_DELAY:      tgd_r     = data[7:0];
      REG_SUB_GROUP_DELAY:  sub_tgd_r = data[0];
      default: ;            // unknown index: dropped
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_terms(logic [31:0] a0, a1, a2, toc, e, ra, tgd, sub);
    write_reg(REG_CLOCK_BIAS, a0);
    write_reg(REG_CLOCK_DRIFT, a1);
    write_reg(REG_CLOCK_DRIFT_RATE, a2);
    write_reg(REG_CLOCK_EPOCH, toc);
    write_reg(REG_ECCENTRICITY, e);
    write_reg(REG_ROOT_A, ra);
    write_reg(REG_GROUP_DELAY, tgd);
    write_reg(REG_SUB_GROUP_DELAY, sub);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (corr_fifo.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [WEEK_W-1:0] rand_week();
    logic [WEEK_W-1:0] wk;
    logic [63:0] toc;
    toc = {48'd0, epoch_r} << 20;
    case ($urandom_range(0, 5))
      0: wk = {4'($urandom_range(0, 15)), $urandom()};   // any 36-bit value
      1: wk = WEEK_W'(toc + 64'($urandom_range(0, 2000)) - 64'd1000);
      2: wk = WEEK_W'(toc + 64'(HALF_WK) + 64'($urandom_range(0, 4)) - 64'd2);
      default: begin
        wk = {4'($urandom_range(0, 9)), $urandom()};
        if (wk >= WEEK_W'(FULL_WK)) wk = wk - WEEK_W'(FULL_WK);
      end
    endcase
    return wk;
  endfunction

  function automatic logic signed [ANG_W-1:0] rand_angle();
    case ($urandom_range(0, 9))
      0: return 32'sh80000000;
      1: return 32'sh40000000 + $signed($urandom_range(0, 4)) - 2;
      2: return -32'sh40000000 + $signed($urandom_range(0, 4)) - 2;
      default: return $urandom();
    endcase
  endfunction

  // directed queries: range edges, wrap points and the special angles
  query_t edge_tab[] = '{
    '{36'd0,            32'sd0},
    '{36'hFFFFFFFFF,    32'sh7FFFFFFF},
    '{36'd39636172799,  32'sh80000000},
    '{36'd19818086400,  32'sh40000000},
    '{36'd19818086401,  -32'sh40000000},
    '{36'd39636172800,  32'sh40000001},
    '{36'd1048576,      -32'sh40000001},
    '{36'd39635124224,  32'sh20000000},
    '{36'd255,          32'sd1},
    '{36'd256,          -32'sd1},
    '{36'd512,          32'sh60000000},
    '{36'd34359738368,  -32'sh60000000}
  };

  task automatic run_edges(bit pin_zero);
    corr_t zero;
    zero = '0;
    foreach (edge_tab[i]) begin
      pinned_flag.push_back(pin_zero);
      pinned_fifo.push_back(zero);
      send_query(edge_tab[i].week, edge_tab[i].ang);
    end
    drain();
    pinned_flag.delete();
    pinned_fifo.delete();
  endtask

  task automatic run_random(int count);
    repeat (count) send_query(rand_week(), rand_angle());
    drain();
  endtask

  initial begin
    int configs;
    af0_r = '0; af1_r = '0; af2_r = '0; epoch_r = '0;
    ecc_r = '0; root_a_r = '0; tgd_r = '0; sub_tgd_r = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // after reset every term is zero, so every result is zero
    run_edges(1'b1);

    // largest positive terms, epoch at the end of the week
    load_terms(32'h1FFFFF, 32'h7FFF, 32'h7F, 32'd37799, 32'hFFFFFFFF,
               32'hFFFFFFFF, 32'h7F, 32'd1);
    run_edges(1'b0);
    // most negative terms, epoch beyond its legal range
    load_terms(32'h200000, 32'h8000, 32'h80, 32'hFFFF, 32'hFFFFFFFF,
               32'hFFFFFFFF, 32'h80, 32'd1);
    // unknown indices must leave everything alone
    write_reg(4'd8, 32'hFFFFFFFF);
    write_reg(4'd15, 32'h0);
    run_edges(1'b0);

    configs = 0;
    calm = 1'b1;
    run_random(100);     // back-to-back stretch, no stalls
    calm = 1'b0;
    repeat (8) begin
      configs++;
      load_terms($urandom(), $urandom(), $urandom(), $urandom_range(0, 37799),
                 $urandom(), $urandom(), $urandom(), $urandom());
      run_random((RAND_ITEMS - 100) / 8);
    end
    // plausible broadcast values with the delay term off
    load_terms(32'h000F00, 32'hFFF0, 32'h00, 32'd22500, 32'h01000000,
               32'hA10D0000, 32'hF6, 32'd0);
    run_random(50);

    $display("covered %0d results over %0d random register sets plus edge sets",
             results_seen, configs);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/gpscc_pkg.sv
rtl/gps_satellite_clock_correction_core.sv
rtl/gpscc_checker.sv
test/tb_top.sv
